// ----- rtl/wvwap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP package
// Shared widths, payload types and a helper function for the VWAP engine.
// ----------------------------------------------------------------------------
package wvwap_pkg;

   localparam int FIELD_W              = 20;
   localparam int LEN_W                = 7;
   localparam int SUM_W                = 64;
   localparam int DEFAULT_WINDOW_DEPTH = 64;
   localparam int MAX_WINDOW_DEPTH     = 1024;
   localparam int SPAN_W               = $clog2(MAX_WINDOW_DEPTH + 1);
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

   typedef struct packed {
      logic [FIELD_W-1:0] trade_price;
      logic [FIELD_W-1:0] trade_qty;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] vwap_all;
      logic [FIELD_W-1:0] vwap_recent;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] trade_price;
      logic [FIELD_W-1:0] trade_qty;
      logic [SPAN_W-1:0]  span;
   } job_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

// ----- rtl/windowed_vwap_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP engine
// Returns the all-time and the sliding window VWAP for each trade request.
// ----------------------------------------------------------------------------
// Once a request is accepted and reaches the back end, one memory read is made per
// trade in its window, then two 64-bit dividers run side by side at one quotient
// bit per cycle, and the response is then made valid once the output is free.
// The back end works on one request at a time; a two-entry queue takes new
// requests meanwhile.
// Reset clears the totals, counters and queue, sets the window length to 64, and
// leaves the trade memory uncleared since no unwritten entry is ever read.
module windowed_vwap_engine #(
   parameter int WINDOW_DEPTH = wvwap_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wvwap_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wvwap_pkg::rsp_type             rsp_data,
   input  logic                           csr_wr_en,
   input  logic [wvwap_pkg::LEN_W-1:0]    csr_wr_data
);

   logic               q_full, q_push, q_pop, q_not_empty;
   wvwap_pkg::job_type q_push_data, q_head;

   wvwap_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   wvwap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   wvwap_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/wvwap_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP front end
// Accepts trade requests, holds the window length register, tracks how many
// trades are stored and works out the window span of each request.
// ----------------------------------------------------------------------------
module wvwap_front #(
   parameter int WINDOW_DEPTH = wvwap_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wvwap_pkg::req_type             req_data,
   input  logic                           csr_wr_en,
   input  logic [wvwap_pkg::LEN_W-1:0]    csr_wr_data,
   input  logic                           q_full,
   output logic                           q_push,
   output wvwap_pkg::job_type             q_push_data
);

   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W = (CNT_W > wvwap_pkg::LEN_W) ? CNT_W : wvwap_pkg::LEN_W;

   logic [wvwap_pkg::LEN_W-1:0] win_len_ff, win_len_in;
   logic [CNT_W-1:0]            filled_ff, filled_in;
   logic [CNT_W-1:0]            fill_next;
   logic [wvwap_pkg::LEN_W-1:0] len_v;
   logic [CMP_W-1:0]            len_c, cap_c, fill_c, span_c;
   logic                        accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      len_v     = (win_len_ff == '0) ? wvwap_pkg::LEN_W'(1) : win_len_ff;
      len_c     = CMP_W'(len_v);
      cap_c     = (len_c > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : len_c;
      fill_next = (filled_ff == CNT_W'(WINDOW_DEPTH)) ? filled_ff : filled_ff + 1'b1;
      fill_c    = CMP_W'(fill_next);
      span_c    = (cap_c > fill_c) ? fill_c : cap_c;

      q_push_data.trade_price = req_data.trade_price;
      q_push_data.trade_qty   = req_data.trade_qty;
      q_push_data.span        = wvwap_pkg::SPAN_W'(span_c);

      win_len_in = csr_wr_en ? csr_wr_data : win_len_ff;
      filled_in  = accept ? fill_next : filled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= wvwap_pkg::LEN_RESET;
         filled_ff  <= '0;
      end else begin
         win_len_ff <= win_len_in;
         filled_ff  <= filled_in;
      end
   end

endmodule

// ----- rtl/wvwap_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module wvwap_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wvwap_pkg::job_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output wvwap_pkg::job_type head
);

   localparam int DEPTH = wvwap_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wvwap_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/wvwap_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP divider
// Restoring divider that produces one quotient bit per cycle; a zero divisor
// gives a zero quotient at once.
// ----------------------------------------------------------------------------
module wvwap_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [wvwap_pkg::SUM_W-1:0]      dividend,
   input  logic [wvwap_pkg::SUM_W-1:0]      divisor,
   output logic                             busy,
   output logic [wvwap_pkg::FIELD_W-1:0]    quotient
);

   localparam int W     = wvwap_pkg::SUM_W;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [W:0]       shifted, diff;
   logic             ge;

   assign busy     = busy_ff;
   assign quotient = quo_ff[wvwap_pkg::FIELD_W-1:0];

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      ge      = (shifted >= {1'b0, dvs_ff});
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(W);
         if (divisor == '0) begin
            quo_in  = '0;
            busy_in = 1'b0;
         end else begin
            quo_in  = dividend;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in  = {quo_ff[W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- rtl/wvwap_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP back end
// Stores each trade in the window memory, updates the running totals, walks
// the window to sum it and divides both sums into the response.
// ----------------------------------------------------------------------------
module wvwap_back #(
   parameter int WINDOW_DEPTH = wvwap_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  wvwap_pkg::job_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wvwap_pkg::rsp_type rsp_data
);

   localparam int FW     = wvwap_pkg::FIELD_W;
   localparam int SPW    = wvwap_pkg::SPAN_W;
   localparam int SW     = wvwap_pkg::SUM_W;
   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int WV_W   = 2 * FW + CNT_W;
   localparam int WQ_W   = FW + CNT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2*FW-1:0]    mem_ff [WINDOW_DEPTH];
   logic [2:0]         state_ff, state_in;
   wvwap_pkg::job_type job_ff, job_in;
   logic [SLOT_W-1:0]  wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic [SPW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic               rd_vld_ff, rd_vld_in, prod_vld_ff, prod_vld_in;
   logic [2*FW-1:0]    mem_q_ff;
   logic [2*FW-1:0]    prod_ff, prod_in, item_prod_ff, item_prod_in;
   logic [FW-1:0]      pq_ff, pq_in;
   logic [WV_W-1:0]    wv_ff, wv_in;
   logic [WQ_W-1:0]    wq_ff, wq_in;
   logic [SW-1:0]      tv_ff, tv_in, tq_ff, tq_in;
   logic               out_vld_ff, out_vld_in;
   wvwap_pkg::rsp_type out_ff, out_in;
   logic               mem_we, rd_en, walk_done, div_start;
   logic               busy_all, busy_win;
   logic [FW-1:0]      quo_all, quo_win;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   wvwap_div u_div_all (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tv_ff),
      .divisor  (tq_ff),
      .busy     (busy_all),
      .quotient (quo_all)
   );

   wvwap_div u_div_win (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SW'(wv_ff)),
      .divisor  (SW'(wq_ff)),
      .busy     (busy_win),
      .quotient (quo_win)
   );

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      wr_slot_in   = wr_slot_ff;
      rd_slot_in   = rd_slot_ff;
      rd_cnt_in    = rd_cnt_ff;
      item_prod_in = item_prod_ff;
      wv_in        = wv_ff;
      wq_in        = wq_ff;
      tv_in        = tv_ff;
      tq_in        = tq_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && rsp_stall;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      walk_done    = (rd_cnt_ff == job_ff.span) && !rd_vld_ff && !prod_vld_ff;

      prod_in     = (2*FW)'(mem_q_ff[2*FW-1:FW]) * (2*FW)'(mem_q_ff[FW-1:0]);
      pq_in       = mem_q_ff[FW-1:0];
      prod_vld_in = rd_vld_ff;
      if (prod_vld_ff) begin
         wv_in = wv_ff + WV_W'(prod_ff);
         wq_in = wq_ff + WQ_W'(pq_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               job_in   = q_head;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mem_we       = 1'b1;
            item_prod_in = (2*FW)'(job_ff.trade_price) * (2*FW)'(job_ff.trade_qty);
            tq_in        = wvwap_pkg::sat_add(tq_ff, SW'(job_ff.trade_qty));
            rd_slot_in   = wr_slot_ff;
            wr_slot_in   = (wr_slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                     : wr_slot_ff + 1'b1;
            rd_cnt_in    = '0;
            wv_in        = '0;
            wq_in        = '0;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            tv_in    = wvwap_pkg::sat_add(tv_ff, SW'(item_prod_ff));
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (rd_cnt_ff != job_ff.span) begin
               rd_en      = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               rd_slot_in = (rd_slot_ff == '0) ? SLOT_W'(WINDOW_DEPTH - 1)
                                               : rd_slot_ff - 1'b1;
            end
            if (walk_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!busy_all && !busy_win) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_in.vwap_all    = quo_all;
               out_in.vwap_recent = quo_win;
               out_vld_in         = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wr_slot_ff] <= {job_ff.trade_price, job_ff.trade_qty};
      end
      if (rd_en) begin
         mem_q_ff <= mem_ff[rd_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      rd_slot_ff   <= rd_slot_in;
      rd_cnt_ff    <= rd_cnt_in;
      item_prod_ff <= item_prod_in;
      prod_ff      <= prod_in;
      pq_ff        <= pq_in;
      wv_ff        <= wv_in;
      wq_ff        <= wq_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wr_slot_ff  <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         tv_ff       <= '0;
         tq_ff       <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wr_slot_ff  <= wr_slot_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         tv_ff       <= tv_in;
         tq_ff       <= tq_in;
         out_vld_ff  <= out_vld_in;
      end
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed VWAP engine testbench
// Sends trade requests with random or no gaps against random or no response stalls,
// predicts the all-time and windowed VWAP of every accepted request and
// checks each response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FIELD_W     = wvwap_pkg::FIELD_W;
   localparam int LEN_W       = wvwap_pkg::LEN_W;
   localparam int SUM_W       = wvwap_pkg::SUM_W;
   localparam int DEPTH       = wvwap_pkg::DEFAULT_WINDOW_DEPTH;
   localparam int MAX_WAIT    = 14;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = DEPTH + 80;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 95;
   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   wvwap_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   wvwap_pkg::rsp_type rsp_data;
   logic               csr_wr_en;
   logic [LEN_W-1:0]   csr_wr_data;

   bit [FIELD_W-1:0] hist_price [DEPTH];
   bit [FIELD_W-1:0] hist_qty   [DEPTH];
   int               next_slot   = 0;
   int               stored      = 0;
   bit [SUM_W-1:0]   value_total = '0;
   bit [SUM_W-1:0]   qty_total   = '0;
   bit [LEN_W-1:0]   window_len  = wvwap_pkg::LEN_RESET;

   wvwap_pkg::rsp_type expected_vwaps[$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   bit                 sender_steady;
   bit                 receiver_steady;

   windowed_vwap_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic bit [SUM_W-1:0] add_clamped(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
      bit [SUM_W-1:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   function automatic bit [FIELD_W-1:0] avg_price(bit [SUM_W-1:0] value, bit [SUM_W-1:0] qty);
      bit [SUM_W-1:0] q;
      if (qty == 0) begin
         return '0;
      end
      q = value / qty;
      return q[FIELD_W-1:0];
   endfunction

   function automatic wvwap_pkg::rsp_type predict_vwap(wvwap_pkg::req_type trade);
      wvwap_pkg::rsp_type r;
      bit [SUM_W-1:0]     win_value;
      bit [SUM_W-1:0]     win_qty;
      int                 span;
      int                 slot;
      win_value   = '0;
      win_qty     = '0;
      value_total = add_clamped(value_total,
                                SUM_W'(trade.trade_price) * SUM_W'(trade.trade_qty));
      qty_total   = add_clamped(qty_total, SUM_W'(trade.trade_qty));
      hist_price[next_slot] = trade.trade_price;
      hist_qty[next_slot]   = trade.trade_qty;
      next_slot = (next_slot + 1) % DEPTH;
      if (stored < DEPTH) begin
         stored++;
      end
      span = (window_len == 0) ? 1 : int'(window_len);
      if (span > DEPTH) begin
         span = DEPTH;
      end
      if (span > stored) begin
         span = stored;
      end
      for (int k = 1; k <= span; k++) begin
         slot       = (next_slot + DEPTH - k) % DEPTH;
         win_value += SUM_W'(hist_price[slot]) * SUM_W'(hist_qty[slot]);
         win_qty   += SUM_W'(hist_qty[slot]);
      end
      r.vwap_all    = avg_price(value_total, qty_total);
      r.vwap_recent = avg_price(win_value, win_qty);
      return r;
   endfunction

   function automatic int draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [FIELD_W-1:0] pick_field();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return FIELD_MAX;
         end
         2, 3: begin
            return FIELD_W'($urandom_range(0, 255));
         end
         default: begin
            return FIELD_W'($urandom());
         end
      endcase
   endfunction

   task automatic send_trade(input logic [FIELD_W-1:0] price, input logic [FIELD_W-1:0] qty);
      wvwap_pkg::req_type trade;
      wvwap_pkg::rsp_type want;
      int                 gap;
      trade.trade_price = price;
      trade.trade_qty   = qty;
      gap = draw_wait(sender_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = trade;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_vwap(trade);
      expected_vwaps.insert(expected_vwaps.size(), want);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_vwaps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(input logic [LEN_W-1:0] len);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = len;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      window_len = len;
   endtask

   task automatic test_default_window();
      send_trade(20'd1000, '0);
      send_trade(FIELD_MAX, FIELD_MAX);
      send_trade('0, FIELD_MAX);
      send_trade(FIELD_MAX, 20'd1);
      send_trade(20'd5, 20'd3);
      send_trade(20'd7, '0);
   endtask

   task automatic test_window_limits();
      set_window(LEN_W'(1));
      send_trade(20'd100, 20'd10);
      send_trade(20'd200, '0);
      send_trade(FIELD_MAX, FIELD_MAX);
      set_window(LEN_W'(0));
      send_trade(20'd3, 20'd4);
      send_trade(20'd9, 20'd2);
      send_trade('0, '0);
      set_window(LEN_W'(127));
      send_trade(20'd11, 20'd1);
      send_trade(FIELD_MAX, 20'd2);
      send_trade(20'd1, FIELD_MAX);
      set_window(LEN_W'(65));
      send_trade(20'd4, 20'd4);
      set_window(LEN_W'(2));
      send_trade(20'd8, 20'd8);
      send_trade(20'd16, 20'd1);
   endtask

   task automatic test_random_phases();
      logic [LEN_W-1:0] len;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               len = LEN_W'(1);
            end
            1: begin
               len = LEN_W'(64);
            end
            2: begin
               len = LEN_W'(0);
            end
            3: begin
               len = LEN_W'(127);
            end
            4: begin
               len = LEN_W'(63);
            end
            5: begin
               len = LEN_W'(65);
            end
            default: begin
               len = LEN_W'($urandom_range(0, 127));
            end
         endcase
         set_window(len);
         sender_steady   = (p % 4 == 1) || (p % 4 == 3);
         receiver_steady = (p % 4 == 2) || (p % 4 == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ((i == PHASE_ITEMS / 2) || ($urandom_range(0, 59) == 0)) begin
               wait_quiet();
            end
            send_trade(pick_field(), pick_field());
         end
      end
   endtask

   initial begin : rsp_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = draw_wait(receiver_steady);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_rsp
      wvwap_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vwaps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual all %0d recent %0d",
                     $time, rsp_data.vwap_all, rsp_data.vwap_recent);
            error_count++;
         end else begin
            want = expected_vwaps.pop_front();
            if (rsp_data.vwap_all !== want.vwap_all) begin
               $display("%0t: vwap_all mismatch, expected %0d actual %0d",
                        $time, want.vwap_all, rsp_data.vwap_all);
               error_count++;
            end
            if (rsp_data.vwap_recent !== want.vwap_recent) begin
               $display("%0t: vwap_recent mismatch, expected %0d actual %0d",
                        $time, want.vwap_recent, rsp_data.vwap_recent);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, IDLE_LIMIT);
         $display("FAIL windowed_vwap_engine");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_window();
      test_window_limits();
      test_random_phases();
      wait_quiet();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS windowed_vwap_engine");
      end else begin
         $display("FAIL windowed_vwap_engine");
      end
      $finish;
   end

endmodule

// ----- windowed_vwap_engine.f -----
rtl/wvwap_pkg.sv
rtl/wvwap_front.sv
rtl/wvwap_queue.sv
rtl/wvwap_div.sv
rtl/wvwap_back.sv
rtl/windowed_vwap_engine.sv
tb/sv/tb_top.sv
